// ===== rtl/sla_pkg.sv =====
`default_nettype none
package sla_pkg;

	localparam int LEVELS_DEF     = 8;
	localparam int VALUE_BITS_DEF = 16;
	localparam int TIME_BITS_DEF  = 16;

	// level index width along the cell chain, enough for the largest table
	localparam int CHAIN_LVL_W = 4;
	localparam int OUT_LVL_W   = 3;

	typedef enum logic [1:0] {
		MODE_FWD  = 2'd0,
		MODE_REV  = 2'd1,
		MODE_DEAD = 2'd2,
		MODE_HIZ  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_SKIP = 2'd2
	} status_t;

	// per-cell control from the top level
	typedef struct packed {
		logic rev;
		logic wr;
	} cell_ctl_t;

	// match result rippling down the chain
	typedef struct packed {
		logic                   hit;
		logic [CHAIN_LVL_W-1:0] lvl;
	} chain_t;

endpackage
`default_nettype wire

// ===== rtl/sla_cell.sv =====
`default_nettype none
module sla_cell
	import sla_pkg::*;
#(
	parameter int IDX      = 0,
	parameter int KEY_BITS = 32,
	parameter int UW       = 4
) (
	input  wire logic                clk,
	input  wire cell_ctl_t           ctl,
	input  wire logic [KEY_BITS-1:0] key,
	input  wire logic [UW-1:0]       used,
	input  wire chain_t              chain_in,
	output chain_t                   chain_out
);

	logic [KEY_BITS-1:0] fwd_q;
	logic [KEY_BITS-1:0] rev_q;
	logic                match;

	always_ff @(posedge clk) begin
		if (ctl.wr && !ctl.rev) begin
			fwd_q <= key;
		end
		if (ctl.wr && ctl.rev) begin
			rev_q <= key;
		end
	end

	// only entries below the fill count of the direction take part
	assign match = (UW'(IDX) < used) && ((ctl.rev ? rev_q : fwd_q) == key);

	always_comb begin
		chain_out.hit = chain_in.hit | match;
		chain_out.lvl = match ? CHAIN_LVL_W'(IDX) : chain_in.lvl;
	end

endmodule
`default_nettype wire

// ===== rtl/setpoint_level_assigner.sv =====
`default_nettype none
// The done strobe carrying the result word follows start in the next cycle.
// Throughput: one segment per clock; busy stays low, the cell chain matches
// and updates its tables in the cycle of acceptance.
// done flags every result word; the receiver cannot stall the output.
// Reset: arst_n clears fill counts, abort flag and done; table entries are
// left as they are and are only read below the fill count.
module setpoint_level_assigner
	import sla_pkg::*;
#(
	parameter int LEVELS     = LEVELS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            segment_mode,
	input  wire logic [VALUE_BITS-1:0] voltage,
	input  wire logic [VALUE_BITS-1:0] current,
	input  wire logic [TIME_BITS-1:0]  time_value,
	input  wire logic                  sequence_end,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [1:0]                 out_mode,
	output logic [OUT_LVL_W-1:0]       level,
	output logic [TIME_BITS-1:0]       out_time,
	output logic                       new_level,
	output logic [VALUE_BITS-1:0]      new_voltage,
	output logic [VALUE_BITS-1:0]      new_current,
	output logic                       last_out
);

	localparam int KEY_BITS = 2 * VALUE_BITS;
	localparam int UW       = $clog2(LEVELS + 1);

	logic                  accept;
	logic                  is_dir;
	logic                  rev;
	logic [UW-1:0]         fused_q;
	logic [UW-1:0]         rused_q;
	logic                  aborted_q;
	logic [UW-1:0]         used_sel;
	logic                  full;
	logic [KEY_BITS-1:0]   key;
	logic                  ins;
	logic                  ovf;
	cell_ctl_t             ctl [LEVELS];
	chain_t                chain [LEVELS+1];
	logic [1:0]            status_d;
	logic [OUT_LVL_W-1:0]  level_d;
	logic [CHAIN_LVL_W+OUT_LVL_W-1:0] lvl_ext;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_dir = (segment_mode == MODE_FWD) || (segment_mode == MODE_REV);
	assign rev    = (segment_mode == MODE_REV);
	assign key    = {voltage, current};

	assign used_sel = rev ? rused_q : fused_q;
	assign full     = (used_sel == UW'(LEVELS));

	assign chain[0] = '{hit: 1'b0, lvl: '0};

	for (genvar i = 0; i < LEVELS; i++) begin : g_cell
		always_comb begin
			ctl[i].rev = rev;
			ctl[i].wr  = ins && (used_sel == UW'(i));
		end

		sla_cell #(
			.IDX      (i),
			.KEY_BITS (KEY_BITS),
			.UW       (UW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.key       (key),
			.used      (used_sel),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	assign ins = accept && !aborted_q && is_dir && !chain[LEVELS].hit && !full;
	assign ovf = accept && !aborted_q && is_dir && !chain[LEVELS].hit && full;

	always_comb begin
		lvl_ext = '0;
		level_d = '0;
		if (aborted_q) begin
			status_d = ST_SKIP;
		end else if (ovf) begin
			status_d = ST_OVF;
		end else begin
			status_d = ST_OK;
			if (is_dir) begin
				lvl_ext = chain[LEVELS].hit ? (CHAIN_LVL_W+OUT_LVL_W)'(chain[LEVELS].lvl)
				                            : (CHAIN_LVL_W+OUT_LVL_W)'(used_sel);
				level_d = lvl_ext[OUT_LVL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fused_q   <= '0;
			rused_q   <= '0;
			aborted_q <= 1'b0;
			done      <= 1'b0;
		end else begin
			done <= accept;
			if (accept) begin
				if (sequence_end) begin
					fused_q   <= '0;
					rused_q   <= '0;
					aborted_q <= 1'b0;
				end else begin
					if (ins && !rev) fused_q <= fused_q + UW'(1);
					if (ins && rev)  rused_q <= rused_q + UW'(1);
					if (ovf)         aborted_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status      <= status_d;
			out_mode    <= segment_mode;
			level       <= level_d;
			out_time    <= time_value;
			new_level   <= ins;
			new_voltage <= ins ? voltage : '0;
			new_current <= ins ? current : '0;
			last_out    <= sequence_end;
		end
	end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import sla_pkg::*;

	localparam int NUM_LEVELS     = 8;
	localparam int WATCHDOG_LIMIT = 300;
	localparam int TAIL_CYCLES    = 8;

	typedef struct {
		status_t     st;
		mode_t       mode;
		logic [2:0]  lvl;
		logic [15:0] tm;
		logic        fresh;
		logic [15:0] nv;
		logic [15:0] nc;
		logic        last;
	} seg_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  segment_mode;
	logic [15:0] voltage;
	logic [15:0] current;
	logic [15:0] time_value;
	logic        sequence_end;
	logic        done;
	logic [1:0]  status;
	logic [1:0]  out_mode;
	logic [2:0]  level;
	logic [15:0] out_time;
	logic        new_level;
	logic [15:0] new_voltage;
	logic [15:0] new_current;
	logic        last_out;

	// predictor state
	logic [31:0] fwd_pairs [NUM_LEVELS];
	logic [31:0] rev_pairs [NUM_LEVELS];
	int          fwd_fill = 0;
	int          rev_fill = 0;
	logic        seq_aborted = 1'b0;

	seg_result_t expected_results[$];

	int errors      = 0;
	int n_sent      = 0;
	int n_checked   = 0;
	int n_fresh     = 0;
	int n_overflow  = 0;
	int n_skipped   = 0;
	int quiet_count = 0;

	setpoint_level_assigner u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.segment_mode(segment_mode),
		.voltage     (voltage),
		.current     (current),
		.time_value  (time_value),
		.sequence_end(sequence_end),
		.done        (done),
		.status      (status),
		.out_mode    (out_mode),
		.level       (level),
		.out_time    (out_time),
		.new_level   (new_level),
		.new_voltage (new_voltage),
		.new_current (new_current),
		.last_out    (last_out)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	// Level lookup/assignment for one segment; updates the tables.
	function automatic seg_result_t predict_segment(input mode_t m, input logic [15:0] v,
			input logic [15:0] c, input logic [15:0] t, input logic last);
		seg_result_t r;
		logic [31:0] key;
		int          fill;
		int          hit_at;
		r.st    = ST_OK;
		r.mode  = m;
		r.lvl   = '0;
		r.tm    = t;
		r.fresh = 1'b0;
		r.nv    = '0;
		r.nc    = '0;
		r.last  = last;
		key     = {v, c};
		if (seq_aborted) begin
			r.st = ST_SKIP;
		end else if (m == MODE_FWD || m == MODE_REV) begin
			fill   = (m == MODE_FWD) ? fwd_fill : rev_fill;
			hit_at = -1;
			for (int i = 0; i < fill; i++) begin
				if (hit_at < 0 && ((m == MODE_FWD) ? fwd_pairs[i] : rev_pairs[i]) == key)
					hit_at = i;
			end
			if (hit_at >= 0) begin
				r.lvl = hit_at[2:0];
			end else if (fill >= NUM_LEVELS) begin
				r.st = ST_OVF;
				seq_aborted = 1'b1;
			end else begin
				if (m == MODE_FWD) begin
					fwd_pairs[fill] = key;
					fwd_fill++;
				end else begin
					rev_pairs[fill] = key;
					rev_fill++;
				end
				r.lvl   = fill[2:0];
				r.fresh = 1'b1;
				r.nv    = v;
				r.nc    = c;
			end
		end
		if (last) begin
			fwd_fill    = 0;
			rev_fill    = 0;
			seq_aborted = 1'b0;
		end
		return r;
	endfunction

	// Checks results, predicts accepted words, and runs the watchdog.
	always @(posedge clk) begin
		seg_result_t exp;
		if (arst_n) begin
			if (done) begin
				n_checked++;
				if (expected_results.size() == 0) begin
					report_mismatch("result word with no expectation pending");
				end else begin
					exp = expected_results.pop_front();
					if (status !== exp.st)
						report_mismatch($sformatf("status %0d, expected %0d", status, exp.st));
					if (out_mode !== exp.mode)
						report_mismatch($sformatf("out_mode %0d, expected %0d", out_mode, exp.mode));
					if (level !== exp.lvl)
						report_mismatch($sformatf("level %0d, expected %0d", level, exp.lvl));
					if (out_time !== exp.tm)
						report_mismatch($sformatf("out_time %h, expected %h", out_time, exp.tm));
					if (new_level !== exp.fresh)
						report_mismatch($sformatf("new_level %b, expected %b", new_level, exp.fresh));
					if (new_voltage !== exp.nv)
						report_mismatch($sformatf("new_voltage %h, expected %h", new_voltage, exp.nv));
					if (new_current !== exp.nc)
						report_mismatch($sformatf("new_current %h, expected %h", new_current, exp.nc));
					if (last_out !== exp.last)
						report_mismatch($sformatf("last_out %b, expected %b", last_out, exp.last));
				end
			end
			if (start && !busy) begin
				exp = predict_segment(mode_t'(segment_mode), voltage, current, time_value,
					sequence_end);
				expected_results.insert(expected_results.size(), exp);
				n_sent++;
				if (exp.fresh) n_fresh++;
				if (exp.st == ST_OVF) n_overflow++;
				if (exp.st == ST_SKIP) n_skipped++;
			end
			if (done || (start && !busy))
				quiet_count = 0;
			else
				quiet_count++;
			if (quiet_count >= WATCHDOG_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Called at a rising edge; returns at the edge where the word is taken.
	task automatic send_word(input mode_t m, input logic [15:0] v, input logic [15:0] c,
			input logic [15:0] t, input logic last);
		start        <= 1'b1;
		segment_mode <= m;
		voltage      <= v;
		current      <= c;
		time_value   <= t;
		sequence_end <= last;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Gap with junk on the data lines.
	task automatic idle_for(input int n);
		start        <= 1'b0;
		segment_mode <= 2'($urandom);
		voltage      <= 16'($urandom);
		current      <= 16'($urandom);
		time_value   <= 16'($urandom);
		sequence_end <= 1'($urandom);
		repeat (n) @(posedge clk);
	endtask

	task automatic test_levels();
		send_word(MODE_FWD, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		send_word(MODE_FWD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_word(MODE_FWD, 16'h0000, 16'h0000, 16'h1234, 1'b0);   // hit on level 0
		send_word(MODE_REV, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);   // own table
		send_word(MODE_FWD, 16'hFFFF, 16'h0000, 16'h5555, 1'b0);   // differs in current only
		send_word(MODE_DEAD, 16'hFFFF, 16'hFFFF, 16'hAAAA, 1'b0);
		send_word(MODE_HIZ, 16'hA5A5, 16'h5A5A, 16'hFFFF, 1'b1);
	endtask

	task automatic test_overflow();
		for (int i = 0; i < NUM_LEVELS; i++)
			send_word(MODE_FWD, 16'(i * 16'h1111), 16'(~i), 16'(i), 1'b0);
		send_word(MODE_FWD, 16'h7777, 16'hFFF8, 16'h0100, 1'b0);   // full table, hit on level 7
		send_word(MODE_FWD, 16'hBEEF, 16'h0001, 16'h0200, 1'b0);   // overflow
		send_word(MODE_FWD, 16'h0000, 16'hFFFF, 16'h0300, 1'b0);   // skipped even though known
		send_word(MODE_DEAD, 16'h0000, 16'h0000, 16'h0400, 1'b1);  // skipped, clears
	endtask

	task automatic test_overflow_at_end();
		for (int i = 0; i < NUM_LEVELS; i++)
			send_word(MODE_REV, 16'(16'h8000 | i), 16'(i), 16'hFFFF, 1'b0);
		send_word(MODE_REV, 16'h7FFF, 16'h7FFF, 16'h0001, 1'b1);   // overflow on the last word
		send_word(MODE_REV, 16'h8000, 16'h0000, 16'h0002, 1'b0);   // tables empty again
	endtask

	// Well-formed sequences drawn from a small pair pool so that hits and
	// overflows occur; some sequences are plain noise.
	task automatic run_sequences(input int n_words, input bit with_gaps);
		logic [15:0] pool_v [12];
		logic [15:0] pool_c [12];
		int          pool_n;
		int          seq_len;
		int          sel;
		int          gap_pct;
		bit          noise;
		mode_t       m;
		int          sent;
		sent = 0;
		while (sent < n_words) begin
			pool_n  = $urandom_range(1, 12);
			seq_len = $urandom_range(1, 30);
			noise   = ($urandom_range(0, 9) == 0);
			gap_pct = with_gaps ? (($urandom_range(0, 2) == 0) ? 0 : 35) : 0;
			for (int i = 0; i < pool_n; i++) begin
				pool_v[i] = 16'($urandom);
				pool_c[i] = 16'($urandom);
				// near-miss pairs share one half with entry 0
				if (i > 0 && $urandom_range(0, 3) == 0) begin
					if ($urandom_range(0, 1)) pool_v[i] = pool_v[0];
					else pool_c[i] = pool_c[0];
				end
			end
			for (int s = 0; s < seq_len; s++) begin
				if ($urandom_range(0, 99) < gap_pct)
					idle_for($urandom_range(1, 5));
				sel = $urandom_range(0, 9);
				m   = (sel < 4) ? MODE_FWD : (sel < 8) ? MODE_REV : (sel == 8) ? MODE_DEAD : MODE_HIZ;
				if (noise) begin
					send_word(mode_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
						16'($urandom), ($urandom_range(0, 7) == 0));
				end else begin
					sel = $urandom_range(0, pool_n - 1);
					send_word(m, pool_v[sel], pool_c[sel], 16'($urandom), (s == seq_len - 1));
				end
				sent++;
			end
		end
	endtask

	task automatic test_random_gaps();
		run_sequences(750, 1'b1);
	endtask

	task automatic test_back_to_back();
		run_sequences(150, 1'b0);
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		segment_mode = '0;
		voltage      = '0;
		current      = '0;
		time_value   = '0;
		sequence_end = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_levels();
		test_overflow();
		test_overflow_at_end();
		test_random_gaps();
		test_back_to_back();

		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d segments, checked %0d result words", n_sent, n_checked);
		$display("Fresh levels %0d, overflows %0d, skipped after abort %0d",
			n_fresh, n_overflow, n_skipped);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
